@@ hw/rtl/kwm_pkg.sv @@
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way merge engine: word layouts,
// action codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int KWM_LISTS      = 8;
	localparam int KWM_LIST_DEPTH = 256;

	localparam logic [3:0] KWM_LISTS_IN_USE_RST = 4'd8;
	localparam logic       KWM_IDX_LISTS_IN_USE = 1'b0;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_POP    = 2'd1,
		ACT_CLEAR  = 2'd2
	} kwm_action_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REFILL
	} kwm_state_e;

	typedef struct packed {
		logic [1:0]         action;
		logic [2:0]         list_number;
		logic signed [31:0] value;
	} kwm_req_t;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic [2:0]         source_list;
		logic               all_empty;
	} kwm_rsp_t;

	typedef struct packed {
		logic capture;
		logic do_append;
		logic do_clear;
		logic do_pop;
		logic do_refill;
	} kwm_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       refill_needed;
		logic       out_busy;
	} kwm_sts_t;

endpackage

@@ hw/rtl/k_way_merge_engine_unit.sv @@
// ----------------------------------------------------------------------------
// k_way_merge_engine_unit
// K-way merge of sorted signed lists with an APB register for list count.
// Flow: a request word is captured, then executed; a pop waits in execute while
// the output register holds an untaken result, and a pop that refills the list
// head adds a refill state (one element memory read). One word at a time.
// Reset: lists empty, lists_in_use = 8; element memory is not cleared.
// ----------------------------------------------------------------------------
module k_way_merge_engine_unit #(
	parameter int LISTS      = kwm_pkg::KWM_LISTS,
	parameter int LIST_DEPTH = kwm_pkg::KWM_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  kwm_pkg::kwm_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output kwm_pkg::kwm_rsp_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import kwm_pkg::*;

	logic [3:0] lists_in_use_q;
	logic       reg_hit;
	kwm_cmd_t   cmd;
	kwm_sts_t   sts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == KWM_IDX_LISTS_IN_USE);
	assign prdata  = reg_hit ? {28'd0, lists_in_use_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lists_in_use_q <= KWM_LISTS_IN_USE_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			lists_in_use_q <= pwdata[3:0];
		end
	end

	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kwm_dpath #(
		.LISTS      (LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_lists (lists_in_use_q),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

@@ hw/rtl/kwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer of the merge engine: takes one request word at a time, issues
// the execute command and, after a pop from a list with more elements, the head refill command.
// ----------------------------------------------------------------------------
module kwm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  kwm_pkg::kwm_sts_t sts,
	output kwm_pkg::kwm_cmd_t cmd
);
	import kwm_pkg::*;

	kwm_state_e state_q;
	kwm_state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.action == ACT_POP) begin
					if (!sts.out_busy) begin
						state_d = sts.refill_needed ? ST_REFILL : ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REFILL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		cmd.capture   = (state_q == ST_IDLE) && req_valid;
		cmd.do_append = (state_q == ST_EXEC) && (sts.action == ACT_APPEND);
		cmd.do_clear  = (state_q == ST_EXEC) && (sts.action == ACT_CLEAR);
		cmd.do_pop    = (state_q == ST_EXEC) && (sts.action == ACT_POP) && !sts.out_busy;
		cmd.do_refill = (state_q == ST_REFILL);
	end

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_append, cmd.do_clear, cmd.do_pop, cmd.do_refill}))
		else $error("more than one datapath command");

	a_refill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_refill |-> $past(cmd.do_pop))
		else $error("refill without a preceding pop");

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("captured word not executed");
`endif

endmodule

@@ hw/rtl/kwm_dpath.sv @@
// ----------------------------------------------------------------------------
// kwm_dpath
// Datapath of the merge engine: element memory, per-list length, read
// position and cached head, head compare tree, output register.
// ----------------------------------------------------------------------------
module kwm_dpath #(
	parameter int LISTS      = kwm_pkg::KWM_LISTS,
	parameter int LIST_DEPTH = kwm_pkg::KWM_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:0]        cfg_lists,
	input  kwm_pkg::kwm_req_t req,
	input  kwm_pkg::kwm_cmd_t cmd,
	output kwm_pkg::kwm_sts_t sts,
	output kwm_pkg::kwm_rsp_t rsp,
	output logic              rsp_valid,
	input  logic              rsp_ready
);
	import kwm_pkg::*;

	localparam int LW = $clog2(LISTS);
	localparam int LP = 1 << LW;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = $clog2(LISTS * LIST_DEPTH);

	kwm_req_t           req_q;
	logic [CW-1:0]      len_q [LISTS];
	logic [CW-1:0]      rp_q [LISTS];
	logic signed [31:0] head_q [LISTS];
	logic signed [31:0] mem [LISTS * LIST_DEPTH];
	logic signed [31:0] rdata_q;
	logic [LW-1:0]      refill_idx_q;
	kwm_rsp_t           out_q;
	logic               out_valid_q;

	logic [LISTS-1:0]   lane_avail;
	logic [LISTS-1:0]   lane_more;
	logic [LISTS-1:0]   lane_empty;
	logic [LISTS-1:0]   order_ok;

	logic               node_vld [1:2*LP-1];
	logic               node_more [1:2*LP-1];
	logic signed [31:0] node_val [1:2*LP-1];
	logic [LW-1:0]      node_idx [1:2*LP-1];

	logic               found;
	logic [LW-1:0]      win;
	logic [LW-1:0]      tgt;
	logic               app_ok;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic               rd_en;

	for (genvar i = 0; i < LISTS; i++) begin : g_lane
		assign lane_avail[i] = (rp_q[i] != len_q[i]) && (32'(i) < 32'(cfg_lists));
		assign lane_more[i]  = (rp_q[i] + CW'(1)) < len_q[i];
		assign lane_empty[i] = (rp_q[i] == len_q[i]);
		assign order_ok[i]   = (rp_q[i] <= len_q[i]);
	end

	// min tree, left child wins ties
	always_comb begin
		for (int n = 0; n < LP; n++) begin
			if (n < LISTS) begin
				node_vld[LP+n]  = lane_avail[n];
				node_more[LP+n] = lane_more[n];
				node_val[LP+n]  = head_q[n];
			end else begin
				node_vld[LP+n]  = 1'b0;
				node_more[LP+n] = 1'b0;
				node_val[LP+n]  = '0;
			end
			node_idx[LP+n] = LW'(n);
		end
		for (int n = LP - 1; n >= 1; n--) begin
			if (node_vld[2*n] && (!node_vld[2*n+1] || node_val[2*n] <= node_val[2*n+1])) begin
				node_vld[n]  = node_vld[2*n];
				node_more[n] = node_more[2*n];
				node_val[n]  = node_val[2*n];
				node_idx[n]  = node_idx[2*n];
			end else begin
				node_vld[n]  = node_vld[2*n+1];
				node_more[n] = node_more[2*n+1];
				node_val[n]  = node_val[2*n+1];
				node_idx[n]  = node_idx[2*n+1];
			end
		end
	end

	assign found = node_vld[1];
	assign win   = node_idx[1];

	assign tgt     = LW'(req_q.list_number);
	assign app_ok  = ({1'b0, req_q.list_number} < cfg_lists)
		&& (32'(req_q.list_number) < LISTS)
		&& (len_q[tgt] != CW'(LIST_DEPTH));
	assign wr_addr = AW'(tgt) * AW'(LIST_DEPTH) + AW'(len_q[tgt]);
	assign rd_addr = AW'(win) * AW'(LIST_DEPTH) + AW'(rp_q[win]) + AW'(1);
	assign rd_en   = cmd.do_pop && found && node_more[1];

	assign sts.action        = req_q.action;
	assign sts.refill_needed = found && node_more[1];
	assign sts.out_busy      = out_valid_q && !rsp_ready;

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.do_append && app_ok) begin
			mem[wr_addr] <= req_q.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				len_q[i] <= '0;
				rp_q[i]  <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_clear) begin
				for (int i = 0; i < LISTS; i++) begin
					len_q[i] <= '0;
					rp_q[i]  <= '0;
				end
			end
			if (cmd.do_append && app_ok) begin
				len_q[tgt] <= len_q[tgt] + CW'(1);
			end
			if (cmd.do_pop && found) begin
				rp_q[win] <= rp_q[win] + CW'(1);
			end
			if (cmd.do_pop) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.do_append && app_ok && lane_empty[tgt]) begin
			head_q[tgt] <= req_q.value;
		end
		if (cmd.do_refill) begin
			head_q[refill_idx_q] <= rdata_q;
		end
		if (cmd.do_pop) begin
			refill_idx_q       <= win;
			out_q.merged_value <= found ? node_val[1] : '0;
			out_q.source_list  <= found ? 3'(win) : 3'd0;
			out_q.all_empty    <= !found;
		end
	end

`ifndef NO_ASSERTIONS
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.all_empty) |-> (out_q.merged_value == '0 && out_q.source_list == '0))
		else $error("empty result carries data");

	a_refill_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_refill |-> $past(rd_en))
		else $error("head refill without memory read");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		&order_ok)
		else $error("read position beyond list length");
`endif

endmodule

@@ sim/kwm_merge_checker.sv @@
// ----------------------------------------------------------------------------
// kwm_merge_checker
// Watches the request, result and register channels of the merge engine.
// Predicts each pop result from its own copy of the lists and the list
// count, and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
module kwm_merge_checker #(
	parameter int LISTS      = kwm_pkg::KWM_LISTS,
	parameter int LIST_DEPTH = kwm_pkg::KWM_LIST_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  kwm_pkg::kwm_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  kwm_pkg::kwm_rsp_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	input  logic              end_of_test,
	output int                mismatches,
	output int                outstanding
);
	import kwm_pkg::*;

	localparam logic [2:0] LISTS_IN_USE_ADDR = {KWM_IDX_LISTS_IN_USE, 2'b00};

	logic signed [31:0] list_mem [LISTS][LIST_DEPTH];
	int unsigned        fill_level [LISTS];
	int unsigned        read_level [LISTS];
	logic [3:0]         lists_cfg;
	kwm_rsp_t           pops_due [$];
	int                 fails = 0;
	int                 due = 0;

	assign mismatches  = fails;
	assign outstanding = due;

	task automatic report(input string what);
		$display("%0t kwm check: %s", $time, what);
		fails++;
	endtask

	task automatic merge_step(input kwm_req_t w);
		int                 n;
		bit                 found;
		int                 best;
		logic signed [31:0] best_val;
		logic signed [31:0] head;
		kwm_rsp_t           r;
		n = (lists_cfg < LISTS) ? int'(lists_cfg) : LISTS;
		case (w.action)
			ACT_APPEND: begin
				if (w.list_number < n && fill_level[w.list_number] < LIST_DEPTH) begin
					list_mem[w.list_number][fill_level[w.list_number]] = w.value;
					fill_level[w.list_number]++;
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < LISTS; i++) begin
					fill_level[i] = 0;
					read_level[i] = 0;
				end
			end
			ACT_POP: begin
				found = 0;
				best = 0;
				best_val = '0;
				for (int i = 0; i < n; i++) begin
					if (read_level[i] < fill_level[i]) begin
						head = list_mem[i][read_level[i]];
						if (!found || head < best_val) begin
							found = 1;
							best = i;
							best_val = head;
						end
					end
				end
				r = '0;
				if (found) begin
					read_level[best]++;
					r.merged_value = best_val;
					r.source_list = best[2:0];
				end else begin
					r.all_empty = 1'b1;
				end
				pops_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		kwm_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				fill_level[i] = 0;
				read_level[i] = 0;
			end
			lists_cfg = KWM_LISTS_IN_USE_RST;
			pops_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pops_due.size() == 0) begin
					report("result word with no pop waiting");
				end else begin
					want = pops_due.pop_front();
					if (rsp.merged_value !== want.merged_value)
						report($sformatf("merged_value %0d, expected %0d",
							rsp.merged_value, want.merged_value));
					if (rsp.source_list !== want.source_list)
						report($sformatf("source_list %0d, expected %0d",
							rsp.source_list, want.source_list));
					if (rsp.all_empty !== want.all_empty)
						report($sformatf("all_empty %0b, expected %0b",
							rsp.all_empty, want.all_empty));
				end
			end
			if (req_valid && req_ready)
				merge_step(req);
			if (psel && penable && pready && paddr == LISTS_IN_USE_ADDR) begin
				if (pwrite) begin
					lists_cfg = pwdata[3:0];
				end else if (prdata !== {28'd0, lists_cfg}) begin
					report($sformatf("lists_in_use read %0h, expected %0h",
						prdata, lists_cfg));
				end
			end
		end
		due = pops_due.size();
	end

	always @(posedge end_of_test) begin
		if (pops_due.size() != 0)
			report($sformatf("%0d pop results never came", pops_due.size()));
	end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the k-way merge engine: directed words for the corner cases,
// then phases of sorted append runs with pops, clears and random noise under
// several list counts and idle patterns. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb;

	import kwm_pkg::*;

	localparam logic [1:0] ACT_UNUSED        = 2'd3;
	localparam logic [2:0] LISTS_IN_USE_ADDR = {KWM_IDX_LISTS_IN_USE, 2'b00};
	localparam int         PHASES            = 9;
	localparam int         PHASE_ITEMS       = 60;
	localparam int         HOLD_CYCLES       = 300;
	localparam int         WATCHDOG_LIMIT    = 2000;
	localparam logic [3:0] PHASE_LISTS [PHASES] =
		'{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd8};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	kwm_req_t    req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	kwm_rsp_t    rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        end_of_test = 1'b0;
	int          mismatches;
	int          outstanding;

	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          hold_rx = 0;
	logic [3:0]  cfg_count = KWM_LISTS_IN_USE_RST;
	int          items_sent = 0;

	k_way_merge_engine_unit #(
		.LISTS(KWM_LISTS),
		.LIST_DEPTH(KWM_LIST_DEPTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	kwm_merge_checker #(
		.LISTS(KWM_LISTS),
		.LIST_DEPTH(KWM_LIST_DEPTH)
	) merge_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.end_of_test(end_of_test), .mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int lists_live();
		return (cfg_count < KWM_LISTS) ? int'(cfg_count) : KWM_LISTS;
	endfunction

	// one request word; valid stays high after acceptance until the next call or wait_quiet
	task automatic put(input logic [1:0] act, input logic [2:0] lst, input logic [31:0] val);
		kwm_req_t w;
		w.action = act;
		w.list_number = lst;
		w.value = val;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!(req_valid && req_ready));
		if (act == ACT_POP || act == ACT_CLEAR || (act == ACT_APPEND && lst < lists_live()))
			items_sent++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_access(input bit wr, input logic [3:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= LISTS_IN_USE_ADDR;
		pwdata <= {28'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr)
			cfg_count = v;
	endtask

	// sorted runs mostly over the live lists, pops interleaved, tail pops and sometimes a clear
	task automatic merge_burst();
		longint tail [KWM_LISTS];
		longint base;
		int     n_app;
		int     owed;
		int     lst;
		if ($urandom_range(0, 3) == 0)
			base = longint'($signed($urandom));
		else
			base = longint'($urandom_range(0, 200)) - 100;
		for (int i = 0; i < KWM_LISTS; i++)
			tail[i] = base + $urandom_range(0, 4);
		n_app = $urandom_range(1, 24);
		owed = 0;
		for (int i = 0; i < n_app; i++) begin
			if (lists_live() > 0 && $urandom_range(0, 9) != 0)
				lst = $urandom_range(0, lists_live() - 1);
			else
				lst = $urandom_range(0, KWM_LISTS - 1);
			if ($urandom_range(0, 7) == 0)
				tail[lst] += $urandom_range(0, 1 << 24);
			else
				tail[lst] += $urandom_range(0, 3);
			if (tail[lst] > 64'sd2147483647)
				tail[lst] = 64'sd2147483647;
			put(ACT_APPEND, lst[2:0], tail[lst][31:0]);
			owed++;
			if ($urandom_range(0, 4) == 0) begin
				put(ACT_POP, 3'($urandom), $urandom);
				owed--;
			end
		end
		if ($urandom_range(0, 3) == 0)
			owed = owed / 2;
		owed += $urandom_range(0, 2);
		while (owed > 0) begin
			put(ACT_POP, 3'($urandom), $urandom);
			owed--;
		end
		if ($urandom_range(0, 4) == 0)
			put(ACT_CLEAR, 3'($urandom), $urandom);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				rsp_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_rx = 0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int     quota;
		longint run_val;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_access(1'b1, 4'd8);
		cfg_access(1'b0, 4'd0);

		// corner words: empty pop, extremes, tie, unused action, clear
		put(ACT_POP, 3'd5, 32'hFFFF_FFFF);
		put(ACT_APPEND, 3'd0, 32'd0);
		put(ACT_APPEND, 3'd7, 32'h7FFF_FFFF);
		put(ACT_APPEND, 3'd3, 32'h8000_0000);
		put(ACT_APPEND, 3'd5, 32'hFFFF_FFFF);
		put(ACT_APPEND, 3'd2, 32'd5);
		put(ACT_APPEND, 3'd1, 32'd5);
		put(ACT_APPEND, 3'd4, 32'd1);
		put(ACT_UNUSED, 3'd6, 32'hA5A5_5A5A);
		repeat (8) put(ACT_POP, 3'd7, 32'h5A5A_A5A5);
		put(ACT_APPEND, 3'd6, 32'd7);
		put(ACT_CLEAR, 3'd7, 32'hFFFF_FFFF);
		put(ACT_POP, 3'd0, 32'd0);
		put(ACT_APPEND, 3'd0, 32'd3);
		put(ACT_POP, 3'd0, 32'd0);
		put(ACT_POP, 3'd0, 32'd0);
		put(ACT_APPEND, 3'd0, 32'd9);
		put(ACT_POP, 3'd0, 32'd0);

		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				tx_idle_pct = 33;
				rx_idle_pct = 73;
			end else if (p < 6) begin
				tx_idle_pct = 73;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			wait_quiet();
			cfg_access(1'b1, PHASE_LISTS[p]);
			cfg_access(1'b0, 4'd0);

			if (p == 0) begin
				// overfill one list, then drain it past empty
				put(ACT_CLEAR, 3'd0, 32'd0);
				run_val = longint'($signed($urandom)) >>> 2;
				for (int i = 0; i < KWM_LIST_DEPTH + 3; i++) begin
					put(ACT_APPEND, 3'd2, run_val[31:0]);
					run_val += $urandom_range(0, 2);
				end
				repeat (KWM_LIST_DEPTH + 4) put(ACT_POP, 3'($urandom), $urandom);
			end
			if (p == 1) begin
				hold_rx = 1;
				merge_burst();
				repeat (12) put(ACT_POP, 3'($urandom), $urandom);
			end

			quota = items_sent + PHASE_ITEMS;
			while (items_sent < quota) begin
				case ($urandom_range(0, 9))
					0, 1: repeat ($urandom_range(1, 6))
						put(2'($urandom), 3'($urandom), $urandom);
					2: begin
						put(ACT_CLEAR, 3'($urandom), $urandom);
						put(ACT_POP, 3'($urandom), $urandom);
					end
					default: merge_burst();
				endcase
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		end_of_test = 1'b1;
		@(negedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/kwm_dpath.sv
hw/rtl/k_way_merge_engine_unit.sv
sim/kwm_merge_checker.sv
sim/tb.sv
